// ===== rtl/rtn_pkg.sv =====
// shared types, constants and the product schedule for the nearest-hit ray/triangle block
// no dependencies; every other rtl file refers to this package by scoped names
package rtn_pkg;

    // field and datapath widths
    localparam int COORD_W        = 32;
    localparam int EDGE_W         = COORD_W + 1;
    localparam int WIDE_W         = 2 * EDGE_W + 1;
    localparam int ACC_W          = 102;
    localparam int UVT_FRAC       = 30;
    localparam int PARAM_W        = UVT_FRAC + 1;
    localparam int INDEX_BITS_DEF = 16;

    // configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = COORD_W;

    // queue between front and back, depth is a power of two
    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // multiplier digit loop
    localparam int MUL_DIGIT_W = 8;
    localparam int MUL_DIGITS  = 5;
    localparam int MUL_M_W     = MUL_DIGIT_W * MUL_DIGITS;
    localparam int MUL_CNT_W   = $clog2(MUL_DIGITS);

    // divider step count
    localparam int DIV_CNT_W = $clog2(PARAM_W);

    // product schedule
    localparam int               OP_W        = 5;
    localparam logic [OP_W-1:0]  OP_DET_LAST = 5'd8;
    localparam logic [OP_W-1:0]  OP_TN_LAST  = 5'd23;
    localparam logic [OP_W-1:0]  OP_LAST     = 5'd29;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [EDGE_W-1:0]  edge_t;
    typedef logic signed [WIDE_W-1:0]  wide_t;
    typedef logic signed [ACC_W-1:0]   acc_t;

    // register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_ORIGIN_X,
        CFG_ORIGIN_Y,
        CFG_ORIGIN_Z,
        CFG_SEGMENT_X,
        CFG_SEGMENT_Y,
        CFG_SEGMENT_Z
    } cfg_reg_t;

    // one triangle after the front has formed its edges
    typedef struct packed {
        coord_t [2:0] a;
        edge_t  [2:0] e1;
        edge_t  [2:0] e2;
        edge_t  [2:0] t;
        logic         last;
    } tri_t;

    typedef enum logic [1:0] {A_E1, A_E2, A_P, A_Q} a_src_t;
    typedef enum logic [2:0] {M_S, M_T, M_E1, M_E2, M_UQ, M_VQ} m_src_t;
    typedef enum logic [2:0] {D_NONE, D_P, D_Q, D_DET, D_UN, D_VN, D_TN, D_H} dst_t;
    typedef enum logic [1:0] {DIV_U, DIV_V, DIV_T} div_sel_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_MUL,
        BK_MWAIT,
        BK_DETCHK,
        BK_NORM,
        BK_CHECK,
        BK_DIV,
        BK_DWAIT,
        BK_COORD,
        BK_FINISH
    } back_state_t;

    // one product of the schedule and what to do with the running sum
    typedef struct packed {
        a_src_t     a_src;
        logic [1:0] a_k;
        m_src_t     m_src;
        logic [1:0] m_k;
        logic       lead;
        logic       neg;
        dst_t       dst;
        logic [1:0] d_k;
    } op_t;

    function automatic op_t mk_op(input a_src_t as, input logic [1:0] ak, input m_src_t ms,
                                  input logic [1:0] mk, input logic ld, input logic ng,
                                  input dst_t ds, input logic [1:0] dk);
        op_t o;
        o.a_src = as;
        o.a_k   = ak;
        o.m_src = ms;
        o.m_k   = mk;
        o.lead  = ld;
        o.neg   = ng;
        o.dst   = ds;
        o.d_k   = dk;
        return o;
    endfunction

    // P = S x E2, det, un, Q = T x E1, vn, tn, then the hit point sums
    function automatic op_t op_entry(input logic [OP_W-1:0] op);
        op_t r;
        unique case (op)
            5'd0:    r = mk_op(A_E2, 2'd2, M_S,  2'd1, 1'b1, 1'b0, D_NONE, 2'd0);
            5'd1:    r = mk_op(A_E2, 2'd1, M_S,  2'd2, 1'b0, 1'b1, D_P,    2'd0);
            5'd2:    r = mk_op(A_E2, 2'd0, M_S,  2'd2, 1'b1, 1'b0, D_NONE, 2'd0);
            5'd3:    r = mk_op(A_E2, 2'd2, M_S,  2'd0, 1'b0, 1'b1, D_P,    2'd1);
            5'd4:    r = mk_op(A_E2, 2'd1, M_S,  2'd0, 1'b1, 1'b0, D_NONE, 2'd0);
            5'd5:    r = mk_op(A_E2, 2'd0, M_S,  2'd1, 1'b0, 1'b1, D_P,    2'd2);
            5'd6:    r = mk_op(A_P,  2'd0, M_E1, 2'd0, 1'b1, 1'b0, D_NONE, 2'd0);
            5'd7:    r = mk_op(A_P,  2'd1, M_E1, 2'd1, 1'b0, 1'b0, D_NONE, 2'd0);
            5'd8:    r = mk_op(A_P,  2'd2, M_E1, 2'd2, 1'b0, 1'b0, D_DET,  2'd0);
            5'd9:    r = mk_op(A_P,  2'd0, M_T,  2'd0, 1'b1, 1'b0, D_NONE, 2'd0);
            5'd10:   r = mk_op(A_P,  2'd1, M_T,  2'd1, 1'b0, 1'b0, D_NONE, 2'd0);
            5'd11:   r = mk_op(A_P,  2'd2, M_T,  2'd2, 1'b0, 1'b0, D_UN,   2'd0);
            5'd12:   r = mk_op(A_E1, 2'd2, M_T,  2'd1, 1'b1, 1'b0, D_NONE, 2'd0);
            5'd13:   r = mk_op(A_E1, 2'd1, M_T,  2'd2, 1'b0, 1'b1, D_Q,    2'd0);
            5'd14:   r = mk_op(A_E1, 2'd0, M_T,  2'd2, 1'b1, 1'b0, D_NONE, 2'd0);
            5'd15:   r = mk_op(A_E1, 2'd2, M_T,  2'd0, 1'b0, 1'b1, D_Q,    2'd1);
            5'd16:   r = mk_op(A_E1, 2'd1, M_T,  2'd0, 1'b1, 1'b0, D_NONE, 2'd0);
            5'd17:   r = mk_op(A_E1, 2'd0, M_T,  2'd1, 1'b0, 1'b1, D_Q,    2'd2);
            5'd18:   r = mk_op(A_Q,  2'd0, M_S,  2'd0, 1'b1, 1'b0, D_NONE, 2'd0);
            5'd19:   r = mk_op(A_Q,  2'd1, M_S,  2'd1, 1'b0, 1'b0, D_NONE, 2'd0);
            5'd20:   r = mk_op(A_Q,  2'd2, M_S,  2'd2, 1'b0, 1'b0, D_VN,   2'd0);
            5'd21:   r = mk_op(A_Q,  2'd0, M_E2, 2'd0, 1'b1, 1'b0, D_NONE, 2'd0);
            5'd22:   r = mk_op(A_Q,  2'd1, M_E2, 2'd1, 1'b0, 1'b0, D_NONE, 2'd0);
            5'd23:   r = mk_op(A_Q,  2'd2, M_E2, 2'd2, 1'b0, 1'b0, D_TN,   2'd0);
            5'd24:   r = mk_op(A_E1, 2'd0, M_UQ, 2'd0, 1'b1, 1'b0, D_NONE, 2'd0);
            5'd25:   r = mk_op(A_E2, 2'd0, M_VQ, 2'd0, 1'b0, 1'b0, D_H,    2'd0);
            5'd26:   r = mk_op(A_E1, 2'd1, M_UQ, 2'd0, 1'b1, 1'b0, D_NONE, 2'd0);
            5'd27:   r = mk_op(A_E2, 2'd1, M_VQ, 2'd0, 1'b0, 1'b0, D_H,    2'd1);
            5'd28:   r = mk_op(A_E1, 2'd2, M_UQ, 2'd0, 1'b1, 1'b0, D_NONE, 2'd0);
            5'd29:   r = mk_op(A_E2, 2'd2, M_VQ, 2'd0, 1'b0, 1'b0, D_H,    2'd2);
            default: r = mk_op(A_E1, 2'd0, M_S,  2'd0, 1'b1, 1'b0, D_NONE, 2'd0);
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/rtn_front.sv =====
// front part: takes triangle requests, forms edges and origin offset, queues them
// depends on rtn_pkg
module rtn_front #(
    parameter int IDX_W = rtn_pkg::INDEX_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  rtn_pkg::coord_t [2:0]       a,
    input  rtn_pkg::coord_t [2:0]       b,
    input  rtn_pkg::coord_t [2:0]       c,
    input  logic [IDX_W-1:0]            idx,
    input  logic                        last,
    input  rtn_pkg::coord_t [2:0]       origin,
    output logic                        q_valid,
    input  logic                        q_pop,
    output rtn_pkg::tri_t               q_item,
    output logic [IDX_W-1:0]            q_idx
);

    rtn_pkg::tri_t                   item_d;
    rtn_pkg::tri_t                   mem_reg [rtn_pkg::QUEUE_DEPTH];
    logic [IDX_W-1:0]                idx_mem_reg [rtn_pkg::QUEUE_DEPTH];
    logic [rtn_pkg::PTR_W-1:0]       wr_ptr_reg;
    logic [rtn_pkg::PTR_W-1:0]       rd_ptr_reg;
    logic [rtn_pkg::CNT_W-1:0]       count_reg;
    logic [rtn_pkg::CNT_W-1:0]       count_next;
    logic                            do_wr;
    logic                            do_rd;

    // edges and origin offset, each 33 bits so the difference is exact
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            item_d.a[k]  = a[k];
            item_d.e1[k] = {b[k][rtn_pkg::COORD_W-1], b[k]} - {a[k][rtn_pkg::COORD_W-1], a[k]};
            item_d.e2[k] = {c[k][rtn_pkg::COORD_W-1], c[k]} - {a[k][rtn_pkg::COORD_W-1], a[k]};
            item_d.t[k]  = {origin[k][rtn_pkg::COORD_W-1], origin[k]}
                         - {a[k][rtn_pkg::COORD_W-1], a[k]};
        end
        item_d.last = last;
    end

    assign full    = (count_reg == rtn_pkg::CNT_W'(rtn_pkg::QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign do_wr   = push && !full;
    assign do_rd   = q_pop && q_valid;
    assign q_item  = mem_reg[rd_ptr_reg];
    assign q_idx   = idx_mem_reg[rd_ptr_reg];

    // queue occupancy
    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_wr && do_rd)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg]     <= item_d;
            idx_mem_reg[wr_ptr_reg] <= idx;
        end
    end

endmodule

// ===== rtl/rtn_mul.sv =====
// shared multiplier: 67-bit signed by 33-bit signed, eight multiplier bits a cycle
// depends on rtn_pkg
module rtn_mul (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  rtn_pkg::wide_t       a,
    input  rtn_pkg::edge_t       m,
    output logic                 done,
    output rtn_pkg::acc_t        prod
);

    localparam int PART_W = rtn_pkg::WIDE_W + rtn_pkg::MUL_DIGIT_W + 1;

    rtn_pkg::wide_t                     a_reg;
    logic [rtn_pkg::MUL_M_W-1:0]        m_reg;
    rtn_pkg::acc_t                      acc_reg;
    rtn_pkg::acc_t                      acc_next;
    logic [rtn_pkg::MUL_CNT_W-1:0]      cnt_reg;
    logic                               busy_reg;
    logic                               done_reg;
    logic signed [rtn_pkg::MUL_DIGIT_W:0] dig;
    logic signed [PART_W-1:0]           part;
    logic                               at_end;

    // top digit carries the sign, the rest are unsigned
    always_comb
    begin
        if (cnt_reg == '0)
        begin
            dig = {m_reg[rtn_pkg::MUL_M_W-1],
                   m_reg[rtn_pkg::MUL_M_W-1 -: rtn_pkg::MUL_DIGIT_W]};
        end
        else
        begin
            dig = {1'b0, m_reg[rtn_pkg::MUL_M_W-1 -: rtn_pkg::MUL_DIGIT_W]};
        end
        part     = a_reg * dig;
        acc_next = {acc_reg[rtn_pkg::ACC_W-1-rtn_pkg::MUL_DIGIT_W:0],
                    {rtn_pkg::MUL_DIGIT_W{1'b0}}}
                 + {{(rtn_pkg::ACC_W-PART_W){part[PART_W-1]}}, part};
    end

    assign at_end = (cnt_reg == rtn_pkg::MUL_CNT_W'(rtn_pkg::MUL_DIGITS - 1));
    assign done   = done_reg;
    assign prod   = acc_reg;

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && at_end;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (at_end)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // operands and partial sum, most significant digit first
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            m_reg   <= {{(rtn_pkg::MUL_M_W-rtn_pkg::EDGE_W){m[rtn_pkg::EDGE_W-1]}}, m};
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= (cnt_reg == '0) ? {{(rtn_pkg::ACC_W-PART_W){part[PART_W-1]}}, part}
                                       : acc_next;
            m_reg   <= {m_reg[rtn_pkg::MUL_M_W-1-rtn_pkg::MUL_DIGIT_W:0],
                        {rtn_pkg::MUL_DIGIT_W{1'b0}}};
        end
    end

endmodule

// ===== rtl/rtn_div.sv =====
// fraction divider: floor(num * 2^30 / den) for 0 <= num <= den, one quotient bit a cycle
// depends on rtn_pkg
module rtn_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  rtn_pkg::acc_t               num,
    input  rtn_pkg::acc_t               den,
    output logic                        done,
    output logic [rtn_pkg::PARAM_W-1:0] quo
);

    logic [rtn_pkg::ACC_W-1:0]     rem_reg;
    logic [rtn_pkg::ACC_W-1:0]     den_reg;
    logic [rtn_pkg::PARAM_W-1:0]   q_reg;
    logic [rtn_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;
    logic [rtn_pkg::ACC_W-1:0]     cand;
    logic                          ge;
    logic                          at_end;

    // first step compares without doubling, later steps double the remainder
    always_comb
    begin
        cand = (cnt_reg == '0) ? rem_reg : {rem_reg[rtn_pkg::ACC_W-2:0], 1'b0};
        ge   = (cand >= den_reg);
    end

    assign at_end = (cnt_reg == rtn_pkg::DIV_CNT_W'(rtn_pkg::PARAM_W - 1));
    assign done   = done_reg;
    assign quo    = q_reg;

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && at_end;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (at_end)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // remainder and quotient
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num;
            den_reg <= den;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? (cand - den_reg) : cand;
            q_reg   <= {q_reg[rtn_pkg::PARAM_W-2:0], ge};
        end
    end

endmodule

// ===== rtl/rtn_back.sv =====
// back part: sequences the intersection math over the shared multiplier and divider,
// keeps the nearest hit and holds the result register; depends on rtn_pkg, rtn_mul, rtn_div
module rtn_back #(
    parameter int IDX_W = rtn_pkg::INDEX_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_pop,
    input  rtn_pkg::tri_t               in_item,
    input  logic [IDX_W-1:0]            in_idx,
    input  rtn_pkg::coord_t [2:0]       segment,
    output logic                        empty,
    input  logic                        pop,
    output logic                        hit_found,
    output logic [IDX_W-1:0]            hit_index,
    output logic [rtn_pkg::PARAM_W-1:0] hit_param,
    output rtn_pkg::coord_t [2:0]       hit_p
);

    rtn_pkg::back_state_t           state_reg;
    rtn_pkg::back_state_t           state_next;

    // current triangle
    rtn_pkg::coord_t [2:0]          a_reg;
    rtn_pkg::edge_t  [2:0]          e1_reg;
    rtn_pkg::edge_t  [2:0]          e2_reg;
    rtn_pkg::edge_t  [2:0]          t_reg;
    logic [IDX_W-1:0]               idx_reg;
    logic                           last_reg;

    // intermediate sums
    rtn_pkg::wide_t  [2:0]          p_reg;
    rtn_pkg::wide_t  [2:0]          q_reg;
    rtn_pkg::acc_t                  det_reg;
    rtn_pkg::acc_t                  un_reg;
    rtn_pkg::acc_t                  vn_reg;
    rtn_pkg::acc_t                  tn_reg;
    rtn_pkg::acc_t                  sum_reg;
    rtn_pkg::acc_t   [2:0]          h_reg;
    logic [rtn_pkg::PARAM_W-1:0]    uq_reg;
    logic [rtn_pkg::PARAM_W-1:0]    vq_reg;
    logic [rtn_pkg::PARAM_W-1:0]    tq_reg;
    logic [rtn_pkg::OP_W-1:0]       op_reg;
    rtn_pkg::div_sel_t              div_sel_reg;

    // nearest hit so far
    logic                           have_hit_reg;
    logic [rtn_pkg::PARAM_W-1:0]    best_param_reg;
    logic [IDX_W-1:0]               best_index_reg;
    rtn_pkg::coord_t [2:0]          best_p_reg;

    // result register
    logic                           out_valid_reg;
    logic                           out_found_reg;
    logic [IDX_W-1:0]               out_index_reg;
    logic [rtn_pkg::PARAM_W-1:0]    out_param_reg;
    rtn_pkg::coord_t [2:0]          out_p_reg;

    rtn_pkg::op_t                   op_cur;
    rtn_pkg::wide_t                 mul_a;
    rtn_pkg::edge_t                 mul_m;
    rtn_pkg::acc_t                  mul_prod;
    logic                           mul_start;
    logic                           mul_done;
    rtn_pkg::acc_t                  sum_base;
    rtn_pkg::acc_t                  sum_res;
    rtn_pkg::acc_t                  div_num;
    logic                           div_start;
    logic                           div_done;
    logic [rtn_pkg::PARAM_W-1:0]    div_quo;
    rtn_pkg::acc_t                  sum_uv;
    logic                           is_hit;
    logic                           take_best;
    logic                           emit;
    rtn_pkg::acc_t   [2:0]          coord_sum;

    assign op_cur = rtn_pkg::op_entry(op_reg);

    // multiplicand select
    always_comb
    begin
        unique case (op_cur.a_src)
            rtn_pkg::A_E1: mul_a = {{(rtn_pkg::WIDE_W-rtn_pkg::EDGE_W){
                                      e1_reg[op_cur.a_k][rtn_pkg::EDGE_W-1]}},
                                    e1_reg[op_cur.a_k]};
            rtn_pkg::A_E2: mul_a = {{(rtn_pkg::WIDE_W-rtn_pkg::EDGE_W){
                                      e2_reg[op_cur.a_k][rtn_pkg::EDGE_W-1]}},
                                    e2_reg[op_cur.a_k]};
            rtn_pkg::A_P:  mul_a = p_reg[op_cur.a_k];
            rtn_pkg::A_Q:  mul_a = q_reg[op_cur.a_k];
        endcase
    end

    // multiplier select
    always_comb
    begin
        unique case (op_cur.m_src)
            rtn_pkg::M_S:  mul_m = {segment[op_cur.m_k][rtn_pkg::COORD_W-1],
                                    segment[op_cur.m_k]};
            rtn_pkg::M_T:  mul_m = t_reg[op_cur.m_k];
            rtn_pkg::M_E1: mul_m = e1_reg[op_cur.m_k];
            rtn_pkg::M_E2: mul_m = e2_reg[op_cur.m_k];
            rtn_pkg::M_UQ: mul_m = {{(rtn_pkg::EDGE_W-rtn_pkg::PARAM_W){1'b0}}, uq_reg};
            rtn_pkg::M_VQ: mul_m = {{(rtn_pkg::EDGE_W-rtn_pkg::PARAM_W){1'b0}}, vq_reg};
            default:       mul_m = '0;
        endcase
    end

    // running sum of products
    always_comb
    begin
        sum_base = op_cur.lead ? '0 : sum_reg;
        sum_res  = op_cur.neg ? (sum_base - mul_prod) : (sum_base + mul_prod);
    end

    // divider numerator
    always_comb
    begin
        unique case (div_sel_reg)
            rtn_pkg::DIV_U: div_num = un_reg;
            rtn_pkg::DIV_V: div_num = vn_reg;
            rtn_pkg::DIV_T: div_num = tn_reg;
            default:        div_num = tn_reg;
        endcase
    end

    // range tests on sign-normalized numerators
    always_comb
    begin
        sum_uv = un_reg + vn_reg;
        is_hit = !un_reg[rtn_pkg::ACC_W-1] && (det_reg >= un_reg)
              && !vn_reg[rtn_pkg::ACC_W-1] && (det_reg >= sum_uv)
              && !tn_reg[rtn_pkg::ACC_W-1] && (det_reg >= tn_reg);
    end

    // hit point: vertex plus rounded weighted edges
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            coord_sum[k] = {{(rtn_pkg::ACC_W-rtn_pkg::COORD_W-rtn_pkg::UVT_FRAC){
                              a_reg[k][rtn_pkg::COORD_W-1]}},
                            a_reg[k], {rtn_pkg::UVT_FRAC{1'b0}}}
                         + h_reg[k]
                         + (rtn_pkg::acc_t'(1) <<< (rtn_pkg::UVT_FRAC - 1));
        end
    end

    assign take_best = !have_hit_reg || (tq_reg < best_param_reg);

    // next state and unit strobes
    always_comb
    begin
        state_next = state_reg;
        in_pop     = 1'b0;
        mul_start  = 1'b0;
        div_start  = 1'b0;
        emit       = 1'b0;
        unique case (state_reg)
            rtn_pkg::BK_IDLE:
            begin
                if (in_valid)
                begin
                    in_pop     = 1'b1;
                    state_next = rtn_pkg::BK_MUL;
                end
            end
            rtn_pkg::BK_MUL:
            begin
                mul_start  = 1'b1;
                state_next = rtn_pkg::BK_MWAIT;
            end
            rtn_pkg::BK_MWAIT:
            begin
                if (mul_done)
                begin
                    priority if (op_reg == rtn_pkg::OP_DET_LAST)
                    begin
                        state_next = rtn_pkg::BK_DETCHK;
                    end
                    else if (op_reg == rtn_pkg::OP_TN_LAST)
                    begin
                        state_next = rtn_pkg::BK_NORM;
                    end
                    else if (op_reg == rtn_pkg::OP_LAST)
                    begin
                        state_next = rtn_pkg::BK_COORD;
                    end
                    else
                    begin
                        state_next = rtn_pkg::BK_MUL;
                    end
                end
            end
            rtn_pkg::BK_DETCHK:
            begin
                state_next = (det_reg == '0) ? rtn_pkg::BK_FINISH : rtn_pkg::BK_MUL;
            end
            rtn_pkg::BK_NORM:
            begin
                state_next = rtn_pkg::BK_CHECK;
            end
            rtn_pkg::BK_CHECK:
            begin
                state_next = is_hit ? rtn_pkg::BK_DIV : rtn_pkg::BK_FINISH;
            end
            rtn_pkg::BK_DIV:
            begin
                div_start  = 1'b1;
                state_next = rtn_pkg::BK_DWAIT;
            end
            rtn_pkg::BK_DWAIT:
            begin
                if (div_done)
                begin
                    state_next = (div_sel_reg == rtn_pkg::DIV_T) ? rtn_pkg::BK_MUL
                                                                 : rtn_pkg::BK_DIV;
                end
            end
            rtn_pkg::BK_COORD:
            begin
                state_next = rtn_pkg::BK_FINISH;
            end
            rtn_pkg::BK_FINISH:
            begin
                if (!last_reg)
                begin
                    state_next = rtn_pkg::BK_IDLE;
                end
                else if (!out_valid_reg || pop)
                begin
                    emit       = 1'b1;
                    state_next = rtn_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = rtn_pkg::BK_IDLE;
            end
        endcase
    end

    // state, schedule position, best hit and result flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= rtn_pkg::BK_IDLE;
            op_reg         <= '0;
            div_sel_reg    <= rtn_pkg::DIV_U;
            have_hit_reg   <= 1'b0;
            best_param_reg <= '0;
            best_index_reg <= '0;
            best_p_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_pop)
            begin
                op_reg <= '0;
            end
            else if ((state_reg == rtn_pkg::BK_MWAIT) && mul_done)
            begin
                op_reg <= op_reg + 1'b1;
            end
            if (state_reg == rtn_pkg::BK_CHECK)
            begin
                div_sel_reg <= rtn_pkg::DIV_U;
            end
            else if ((state_reg == rtn_pkg::BK_DWAIT) && div_done)
            begin
                unique case (div_sel_reg)
                    rtn_pkg::DIV_U: div_sel_reg <= rtn_pkg::DIV_V;
                    rtn_pkg::DIV_V: div_sel_reg <= rtn_pkg::DIV_T;
                    default:        div_sel_reg <= rtn_pkg::DIV_U;
                endcase
            end
            // keep the nearest, earlier triangle wins ties
            if ((state_reg == rtn_pkg::BK_COORD) && take_best)
            begin
                have_hit_reg   <= 1'b1;
                best_param_reg <= tq_reg;
                best_index_reg <= idx_reg;
                for (int k = 0; k < 3; k++)
                begin
                    best_p_reg[k] <= coord_sum[k][rtn_pkg::UVT_FRAC+rtn_pkg::COORD_W-1
                                                  : rtn_pkg::UVT_FRAC];
                end
            end
            else if (emit)
            begin
                have_hit_reg   <= 1'b0;
                best_param_reg <= '0;
                best_index_reg <= '0;
                best_p_reg     <= '0;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_pop)
        begin
            a_reg    <= in_item.a;
            e1_reg   <= in_item.e1;
            e2_reg   <= in_item.e2;
            t_reg    <= in_item.t;
            last_reg <= in_item.last;
            idx_reg  <= in_idx;
        end
        if ((state_reg == rtn_pkg::BK_MWAIT) && mul_done)
        begin
            sum_reg <= sum_res;
            unique case (op_cur.dst)
                rtn_pkg::D_P:   p_reg[op_cur.d_k] <= sum_res[rtn_pkg::WIDE_W-1:0];
                rtn_pkg::D_Q:   q_reg[op_cur.d_k] <= sum_res[rtn_pkg::WIDE_W-1:0];
                rtn_pkg::D_DET: det_reg <= sum_res;
                rtn_pkg::D_UN:  un_reg  <= sum_res;
                rtn_pkg::D_VN:  vn_reg  <= sum_res;
                rtn_pkg::D_TN:  tn_reg  <= sum_res;
                rtn_pkg::D_H:   h_reg[op_cur.d_k] <= sum_res;
                default:        ;
            endcase
        end
        // make the determinant positive
        if ((state_reg == rtn_pkg::BK_NORM) && det_reg[rtn_pkg::ACC_W-1])
        begin
            det_reg <= -det_reg;
            un_reg  <= -un_reg;
            vn_reg  <= -vn_reg;
            tn_reg  <= -tn_reg;
        end
        if ((state_reg == rtn_pkg::BK_DWAIT) && div_done)
        begin
            unique case (div_sel_reg)
                rtn_pkg::DIV_U: uq_reg <= div_quo;
                rtn_pkg::DIV_V: vq_reg <= div_quo;
                default:        tq_reg <= div_quo;
            endcase
        end
        if (emit)
        begin
            out_found_reg <= have_hit_reg;
            out_index_reg <= best_index_reg;
            out_param_reg <= best_param_reg;
            out_p_reg     <= best_p_reg;
        end
    end

    assign empty     = !out_valid_reg;
    assign hit_found = out_found_reg;
    assign hit_index = out_index_reg;
    assign hit_param = out_param_reg;
    assign hit_p     = out_p_reg;

    rtn_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .m     (mul_m),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    rtn_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (det_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

endmodule

// ===== rtl/ray_triangle_nearest_hit.sv =====
// top level: ray segment registers, front queue and back sequencer for nearest triangle hit
// depends on rtn_pkg, rtn_front, rtn_back
//
//  channel   handshake          payload
//  config    cfg_we             cfg_index, cfg_data (origin x/y/z, segment x/y/z)
//  triangle  push / full        a_x..c_z, tri_index, last_tri
//  result    empty / pop        hit_found, hit_index, hit_param, hit_x, hit_y, hit_z
//
// one triangle ends after the determinant products when the determinant is zero, after
// the range tests when they fail, and runs the full schedule of 30 products on a hit: each
// product goes through the shared 67x8 multiplier loop, and each of the three fractions
// through the one-bit-a-cycle divider. the two-entry queue takes requests while the back is busy.
// a result waits in its register without stopping the next run's math until that run
// ends. reset zeroes the ray segment registers and the best hit, and empties the queue and result register.
module ray_triangle_nearest_hit #(
    parameter int INDEX_BITS = rtn_pkg::INDEX_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [rtn_pkg::CFG_ADDR_W-1:0] cfg_index,
    input  logic [rtn_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           push,
    output logic                           full,
    input  logic signed [rtn_pkg::COORD_W-1:0] a_x,
    input  logic signed [rtn_pkg::COORD_W-1:0] a_y,
    input  logic signed [rtn_pkg::COORD_W-1:0] a_z,
    input  logic signed [rtn_pkg::COORD_W-1:0] b_x,
    input  logic signed [rtn_pkg::COORD_W-1:0] b_y,
    input  logic signed [rtn_pkg::COORD_W-1:0] b_z,
    input  logic signed [rtn_pkg::COORD_W-1:0] c_x,
    input  logic signed [rtn_pkg::COORD_W-1:0] c_y,
    input  logic signed [rtn_pkg::COORD_W-1:0] c_z,
    input  logic [INDEX_BITS-1:0]          tri_index,
    input  logic                           last_tri,
    output logic                           empty,
    input  logic                           pop,
    output logic                           hit_found,
    output logic [INDEX_BITS-1:0]          hit_index,
    output logic [rtn_pkg::PARAM_W-1:0]    hit_param,
    output logic signed [rtn_pkg::COORD_W-1:0] hit_x,
    output logic signed [rtn_pkg::COORD_W-1:0] hit_y,
    output logic signed [rtn_pkg::COORD_W-1:0] hit_z
);

    rtn_pkg::coord_t [2:0]   origin_reg;
    rtn_pkg::coord_t [2:0]   segment_reg;
    rtn_pkg::coord_t [2:0]   hit_p;
    rtn_pkg::tri_t           q_item;
    logic [INDEX_BITS-1:0]   q_idx;
    logic                    q_valid;
    logic                    q_pop;

    // ray segment registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_reg  <= '0;
            segment_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rtn_pkg::CFG_ORIGIN_X:  origin_reg[0]  <= cfg_data;
                rtn_pkg::CFG_ORIGIN_Y:  origin_reg[1]  <= cfg_data;
                rtn_pkg::CFG_ORIGIN_Z:  origin_reg[2]  <= cfg_data;
                rtn_pkg::CFG_SEGMENT_X: segment_reg[0] <= cfg_data;
                rtn_pkg::CFG_SEGMENT_Y: segment_reg[1] <= cfg_data;
                rtn_pkg::CFG_SEGMENT_Z: segment_reg[2] <= cfg_data;
                default:                ;
            endcase
        end
    end

    rtn_front #(
        .IDX_W (INDEX_BITS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .a       ({a_z, a_y, a_x}),
        .b       ({b_z, b_y, b_x}),
        .c       ({c_z, c_y, c_x}),
        .idx     (tri_index),
        .last    (last_tri),
        .origin  (origin_reg),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_item  (q_item),
        .q_idx   (q_idx)
    );

    rtn_back #(
        .IDX_W (INDEX_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_valid),
        .in_pop    (q_pop),
        .in_item   (q_item),
        .in_idx    (q_idx),
        .segment   (segment_reg),
        .empty     (empty),
        .pop       (pop),
        .hit_found (hit_found),
        .hit_index (hit_index),
        .hit_param (hit_param),
        .hit_p     (hit_p)
    );

    assign hit_x = hit_p[0];
    assign hit_y = hit_p[1];
    assign hit_z = hit_p[2];

endmodule
